@@ rtl/siq_pkg.sv @@
// ----------------------------------------------------------------------------
// siq_pkg: shared types and constants of the symmetric int8 quantizer
// Transaction structs, operation codes, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package siq_pkg;

    // Sample width, signed Q8.8
    localparam int VALUE_BITS = 16;
    // Reported absolute maximum width
    localparam int PEAK_BITS  = 16;
    // Quotient bits: the rounded quotient never exceeds 127
    localparam int QUOT_BITS  = 7;
    // 254 * mag needs eight more bits than the sample
    localparam int SCALE_BITS = VALUE_BITS + 8;
    // 254 * mag + peak stays below 2^(VALUE_BITS + 7)
    localparam int NUM_BITS   = VALUE_BITS + QUOT_BITS;
    localparam int CNT_BITS   = $clog2(QUOT_BITS);

    localparam logic signed [7:0] CODE_MAX  = 8'sd127;
    localparam logic signed [7:0] CODE_ZERO = 8'sd0;

    localparam logic OP_MEASURE  = 1'b0;
    localparam logic OP_QUANTIZE = 1'b1;

    typedef struct packed {
        logic                         operation;
        logic signed [VALUE_BITS-1:0] value;
        logic                         first;
    } sample_t;

    typedef struct packed {
        logic signed [7:0]          quantized;
        logic        [PEAK_BITS-1:0] running_max;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/symmetric_int8_quantizer.sv @@
// ----------------------------------------------------------------------------
// symmetric_int8_quantizer: per-tensor absmax int8 quantizer
// Measure transactions fold |value| into a running absolute maximum; quantize
// transactions return round(127 * value / absmax), half away from zero.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------
//  sample   | sample_valid / sample_stall | siq_pkg::sample_t (op, value, first)
//  result   | result_valid / result_stall | siq_pkg::result_t (quantized, max)
//
//  A measure transaction, or a quantize transaction that needs no division
//  (zero absmax, or sample at or above absmax), goes from idle straight to
//  the finish state. A quantize transaction that divides first forms
//  254 * |value| + absmax, then takes seven restoring steps on the shared
//  subtractor (one quotient bit each); the finish state hands the result over.
//  Reset clears absmax to zero and empties the sequencer and result register.
//  One transaction is worked on at a time; a finished result waits in the
//  output register while the next sample is accepted.
// ----------------------------------------------------------------------------
module symmetric_int8_quantizer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  siq_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output siq_pkg::result_t result
);

    siq_pkg::state_t state_reg, state_next;

    // Running absolute maximum (control state: reset to zero)
    logic [siq_pkg::PEAK_BITS-1:0]  peak_reg, peak_next;

    // Working registers of the division
    logic [siq_pkg::VALUE_BITS-1:0] mag_reg, mag_next;
    logic                           neg_reg, neg_next;
    logic [siq_pkg::NUM_BITS-1:0]   rem_reg, rem_next;
    logic [siq_pkg::NUM_BITS-1:0]   dsh_reg, dsh_next;
    logic [siq_pkg::QUOT_BITS-1:0]  quot_reg, quot_next;
    logic [siq_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic signed [7:0]              code_reg, code_next;

    // Output register
    logic             result_valid_reg, result_valid_next;
    siq_pkg::result_t result_reg, result_next;

    // Sample magnitude; the most negative value maps to 2^(VALUE_BITS-1)
    logic                           sample_neg;
    logic [siq_pkg::VALUE_BITS-1:0] sample_mag;

    // Shared subtractor and numerator build
    logic [siq_pkg::NUM_BITS:0]     trial;
    logic                           fits;
    logic [siq_pkg::SCALE_BITS-1:0] scaled;
    logic [siq_pkg::QUOT_BITS-1:0]  quot_final;
    logic signed [7:0]              quot_code;

    assign sample_neg = sample.value[siq_pkg::VALUE_BITS-1];
    assign sample_mag = sample_neg ? (~sample.value + 1'b1) : sample.value;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign fits  = ~trial[siq_pkg::NUM_BITS];

    // 254 * mag + peak = (mag << 8) - (mag << 1) + peak
    assign scaled = {mag_reg, 8'b0}
                  - {7'b0, mag_reg, 1'b0}
                  + {{(siq_pkg::SCALE_BITS-siq_pkg::PEAK_BITS){1'b0}}, peak_reg};

    assign quot_final = {quot_reg[siq_pkg::QUOT_BITS-2:0], fits};
    assign quot_code  = $signed({1'b0, quot_final});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= siq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            peak_reg         <= peak_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        code_reg   <= code_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        peak_next         = peak_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        quot_next         = quot_reg;
        cnt_next          = cnt_reg;
        code_next         = code_reg;
        result_next       = result_reg;
        // drop the held result once it is taken
        result_valid_next = result_valid_reg & result_stall;
        sample_stall      = (state_reg != siq_pkg::ST_IDLE);

        case (state_reg)
            siq_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    code_next  = siq_pkg::CODE_ZERO;
                    state_next = siq_pkg::ST_FINISH;
                    if (sample.operation == siq_pkg::OP_MEASURE)
                    begin
                        if (sample.first || (sample_mag > peak_reg))
                        begin
                            peak_next = sample_mag;
                        end
                    end
                    else if (peak_reg == '0)
                    begin
                        code_next = siq_pkg::CODE_ZERO;
                    end
                    else if (sample_mag >= peak_reg)
                    begin
                        // saturate by sign
                        code_next = sample_neg ? -siq_pkg::CODE_MAX : siq_pkg::CODE_MAX;
                    end
                    else
                    begin
                        mag_next   = sample_mag;
                        neg_next   = sample_neg;
                        state_next = siq_pkg::ST_SCALE;
                    end
                end
            end

            siq_pkg::ST_SCALE:
            begin
                rem_next   = scaled[siq_pkg::NUM_BITS-1:0];
                // divisor 2 * peak, aligned to the top quotient bit
                dsh_next   = {peak_reg, {siq_pkg::QUOT_BITS{1'b0}}};
                quot_next  = '0;
                cnt_next   = siq_pkg::CNT_BITS'(siq_pkg::QUOT_BITS - 1);
                state_next = siq_pkg::ST_DIVIDE;
            end

            siq_pkg::ST_DIVIDE:
            begin
                if (fits)
                begin
                    rem_next = trial[siq_pkg::NUM_BITS-1:0];
                end
                quot_next = quot_final;
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    code_next  = neg_reg ? -quot_code : quot_code;
                    state_next = siq_pkg::ST_FINISH;
                end
            end

            siq_pkg::ST_FINISH:
            begin
                // hold until the output register is free or being emptied
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.quantized   = code_reg;
                    result_next.running_max = peak_reg;
                    result_valid_next       = 1'b1;
                    state_next              = siq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = siq_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
